FILE: hdl/pfrd_pkg.sv
// pfrd_pkg: shared types and codes for the page framebuffer rectangle drawer.
// No dependencies; imported by the mask unit and the top level.
`default_nettype none

package pfrd_pkg;

  // Signed width that holds any rectangle coordinate, including x+w-1 and y-1.
  localparam int COORD_W = 18;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Rectangle edges: left/right columns, top/bottom rows (inclusive).
  typedef struct packed {
    logic signed [COORD_W-1:0] xl;
    logic signed [COORD_W-1:0] xr;
    logic signed [COORD_W-1:0] yt;
    logic signed [COORD_W-1:0] yb;
    logic                      filled;
  } rect_t;

endpackage

`default_nettype wire

FILE: hdl/pfrd_frame_ram.sv
// pfrd_frame_ram: frame store, one write port and one registered read port.
// No dependencies.
`default_nettype none

module pfrd_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/pfrd_mask_unit.sv
// pfrd_mask_unit: pixel mask of one column byte for the current rectangle.
// Depends on pfrd_pkg (rect_t, COORD_W).
`default_nettype none

module pfrd_mask_unit #(
  parameter int CW = 7,
  parameter int PW = 3
) (
  input  logic [CW-1:0]     col,
  input  logic [PW-1:0]     page,
  input  pfrd_pkg::rect_t   rect,
  output logic [7:0]        mask
);

  import pfrd_pkg::*;

  logic signed [COORD_W-1:0] cpos;
  logic                      col_span;
  logic                      col_edge;

  assign cpos     = $signed({{(COORD_W-CW){1'b0}}, col});
  assign col_span = (cpos >= rect.xl) && (cpos <= rect.xr);
  assign col_edge = (cpos == rect.xl) || (cpos == rect.xr);

  // one lane per row of the byte
  always_comb begin
    logic signed [COORD_W-1:0] rpos;
    logic                      row_span;
    logic                      row_edge;
    mask = 8'h00;
    for (int k = 0; k < 8; k++) begin
      rpos     = $signed({{(COORD_W-PW-3){1'b0}}, page, 3'(k)});
      row_span = (rpos >= rect.yt) && (rpos <= rect.yb);
      row_edge = (rpos == rect.yt) || (rpos == rect.yb);
      if (rect.filled) begin
        mask[k] = col_span && row_span;
      end else begin
        mask[k] = (col_span && row_edge) || (row_span && col_edge);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/page_framebuffer_rectangle_drawer_core.sv
// Page framebuffer rectangle drawer, top level: sequencer, frame store, mask unit.
// Depends on pfrd_pkg, pfrd_frame_ram, pfrd_mask_unit.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one command word: draw a
//    rectangle (outline or filled, set or clear), clear the whole store, or
//    read one page/column byte. Output channel (out_valid/out_stall) returns
//    exactly one word per command: read_byte, zero for anything but a read.
//  - Image is SCREEN_COLUMNS x 8*SCREEN_PAGES pixels, one byte per column
//    per page; bit y%8 of byte [y/8][x] is pixel (x,y). Off-screen points drop.
//  - One command at a time; in_stall stays high until its result is loaded
//    into the output register and drops with that load.
//  - Steps: read S_RDCAP then S_DONE; clear writes every byte; draw runs S_PREP,
//    S_CLIP, then, unless the clipped box is empty, S_BASE, then S_RD (read)
//    and S_WR (modify-write) per column byte in it, as there is one store port pair.
//  - Reset: a clearing pass writes zero to every byte, one per cycle
//    (COLUMNS*PAGES bytes, 1024 by default); in_stall is high meanwhile.
//  - Receiver stall: the result sits in the output register; the next
//    command can already be taken and worked on, and only its final load
//    waits for the output register to empty.
`default_nettype none

module page_framebuffer_rectangle_drawer_core #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_PAGES   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] x,
  input  logic [15:0] y,
  input  logic [7:0]  width,
  input  logic [7:0]  height,
  input  logic        filled,
  input  logic        ink,
  input  logic [2:0]  page,
  input  logic [6:0]  column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_byte
);

  import pfrd_pkg::*;

  localparam int STORE = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int AW    = $clog2(STORE);
  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int RW    = PW + 3;

  localparam logic signed [COORD_W-1:0] COL_MAX = COORD_W'(SCREEN_COLUMNS - 1);
  localparam logic signed [COORD_W-1:0] ROW_MAX = COORD_W'(8 * SCREEN_PAGES - 1);
  localparam logic [AW-1:0]             LAST_ADDR = AW'(STORE - 1);

  // sequencer codes
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_CLIP  = 4'd3;
  localparam logic [3:0] S_BASE  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_RDCAP = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]  state;

  // captured command
  logic signed [15:0] rx;
  logic signed [15:0] ry;
  logic [7:0]  rw;
  logic [7:0]  rh;
  logic        rfill;
  logic        rink;
  rect_t       rect;

  // walk over the clipped box
  logic [CW-1:0] c_start;
  logic [CW-1:0] c_end;
  logic [CW-1:0] wcol;
  logic [PW-1:0] wpage;
  logic [PW-1:0] page_end;
  logic [AW-1:0] page_base;
  logic [AW-1:0] walk_addr;

  logic [AW-1:0] clr_addr;
  logic          clr_item;   // clearing pass belongs to a clear command
  logic          rd_ok;      // read address on screen
  logic [7:0]    result;

  // frame store ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    mask;

  logic          accept;
  logic          out_free;
  logic [12:0]   rd_full;
  logic [AW-1:0] rd_addr_in;
  logic          rd_in_range;

  // clip stage values
  logic signed [COORD_W-1:0] clo, chi, rlo, rhi;
  logic          box_empty;
  logic [CW-1:0] clo_c, chi_c;
  logic [RW-1:0] rlo_c, rhi_c;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign rd_full     = 13'(page) * 13'(SCREEN_COLUMNS) + 13'(column);
  assign rd_addr_in  = rd_full[AW-1:0];
  assign rd_in_range = ({2'b00, page} < 5'(SCREEN_PAGES)) &&
                       ({2'b00, column} < 9'(SCREEN_COLUMNS));

  assign walk_addr = page_base + AW'(wcol);

  // Zero width/height still draws outline sides at x-1..x / y-1..y,
  // so the box spans between both edges in either order.
  always_comb begin
    clo = (rw == 8'd0) ? rect.xr : rect.xl;
    chi = (rw == 8'd0) ? rect.xl : rect.xr;
    rlo = (rh == 8'd0) ? rect.yb : rect.yt;
    rhi = (rh == 8'd0) ? rect.yt : rect.yb;
    box_empty = (chi < 0) || (clo > COL_MAX) || (rhi < 0) || (rlo > ROW_MAX);
    clo_c = (clo < 0) ? '0 : clo[CW-1:0];
    chi_c = (chi > COL_MAX) ? CW'(SCREEN_COLUMNS - 1) : chi[CW-1:0];
    rlo_c = (rlo < 0) ? '0 : rlo[RW-1:0];
    rhi_c = (rhi > ROW_MAX) ? RW'(8 * SCREEN_PAGES - 1) : rhi[RW-1:0];
  end

  // store port steering
  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_WR);
    ram_waddr = (state == S_CLEAR) ? clr_addr : walk_addr;
    if (state == S_CLEAR) begin
      ram_wdata = 8'h00;
    end else if (rink) begin
      ram_wdata = ram_rdata | mask;
    end else begin
      ram_wdata = ram_rdata & ~mask;
    end
    ram_raddr = (state == S_IDLE) ? rd_addr_in : walk_addr;
  end

  pfrd_frame_ram #(
    .DEPTH (STORE),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfrd_mask_unit #(
    .CW (CW),
    .PW (PW)
  ) u_mask (
    .col  (wcol),
    .page (wpage),
    .rect (rect),
    .mask (mask)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_item <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= clr_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            result <= 8'h00;
            unique case (kind)
              KIND_DRAW: begin
                rx    <= $signed(x);
                ry    <= $signed(y);
                rw    <= width;
                rh    <= height;
                rfill <= filled;
                rink  <= ink;
                state <= S_PREP;
              end
              KIND_CLEAR: begin
                clr_addr <= '0;
                clr_item <= 1'b1;
                state    <= S_CLEAR;
              end
              KIND_READ: begin
                rd_ok <= rd_in_range;
                state <= S_RDCAP;
              end
              KIND_NONE: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PREP: begin
          rect.xl     <= COORD_W'(rx);
          rect.xr     <= COORD_W'(rx) + $signed({10'd0, rw}) - COORD_W'(1);
          rect.yt     <= COORD_W'(ry);
          rect.yb     <= COORD_W'(ry) + $signed({10'd0, rh}) - COORD_W'(1);
          rect.filled <= rfill;
          state       <= S_CLIP;
        end
        S_CLIP: begin
          c_start  <= clo_c;
          c_end    <= chi_c;
          wpage    <= rlo_c[RW-1:3];
          page_end <= rhi_c[RW-1:3];
          state    <= box_empty ? S_DONE : S_BASE;
        end
        S_BASE: begin
          page_base <= AW'(32'(wpage) * 32'(SCREEN_COLUMNS));
          wcol      <= c_start;
          state     <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (wcol == c_end) begin
            if (wpage == page_end) begin
              state <= S_DONE;
            end else begin
              wpage     <= wpage + PW'(1);
              page_base <= page_base + AW'(SCREEN_COLUMNS);
              wcol      <= c_start;
              state     <= S_RD;
            end
          end else begin
            wcol  <= wcol + CW'(1);
            state <= S_RD;
          end
        end
        S_RDCAP: begin
          result <= rd_ok ? ram_rdata : 8'h00;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            clr_item <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        read_byte <= result;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pfrd_checker.sv
// pfrd_checker: port-level assertions for the drawer core, bound to the top level.
// Depends on page_framebuffer_rectangle_drawer_core (bind target).
`default_nettype none

module pfrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_byte
);

  // clearing pass after reset holds off input
  a_reset_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_byte)))
    else $error("stalled result changed or dropped");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    ($fell(out_valid) && !$past(rst)) |-> !$past(out_stall))
    else $error("result withdrawn without being taken");

endmodule

bind page_framebuffer_rectangle_drawer_core pfrd_checker u_pfrd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_byte (read_byte)
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for page_framebuffer_rectangle_drawer_core.
// Drives draw, clear, read and unused-kind words and checks each read_byte against a built-in image model.
// Depends on pfrd_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import pfrd_pkg::*;

  localparam int COLS = 128;
  localparam int ROWS = 64;

  // One command word as it sits on the input channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic        filled;
    logic        ink;
    logic [2:0]  page;
    logic [6:0]  column;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [7:0] read_byte;

  // Word on the input ports; changes at falling edges only.
  word_t cur_word = '0;

  word_t       pending_words[$];
  logic  [7:0] expected_bytes[$];
  logic  [7:0] frame_img[0:COLS*ROWS/8-1];

  logic in_fire = 1'b0;   // current word was taken at the last rising edge
  int   words_taken = 0;
  int   total_words = 0;
  bit   failed = 1'b0;

  page_framebuffer_rectangle_drawer_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (cur_word.kind),
    .x        (cur_word.x),
    .y        (cur_word.y),
    .width    (cur_word.width),
    .height   (cur_word.height),
    .filled   (cur_word.filled),
    .ink      (cur_word.ink),
    .page     (cur_word.page),
    .column   (cur_word.column),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_byte(read_byte)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (frame_img[k]) frame_img[k] = 8'h00;
  end

  // ---------------------------------------------------------------------------
  // Image model
  // ---------------------------------------------------------------------------

  // Set or clear one pixel; anything off the screen is dropped.
  function automatic void plot(int px, int py, bit on);
    int idx;
    if (px < 0 || px >= COLS || py < 0 || py >= ROWS) return;
    idx = (py / 8) * COLS + px;
    frame_img[idx][py % 8] = on;
  endfunction

  // Apply one word to the image; returns the byte the block should answer with.
  function automatic logic [7:0] render_word(word_t w);
    int xs, ys, wd, ht, i, j, x_lo, x_hi, y_lo, y_hi;
    logic [7:0] answer;
    answer = 8'h00;
    xs = int'($signed(w.x));
    ys = int'($signed(w.y));
    wd = int'(w.width);
    ht = int'(w.height);
    case (w.kind)
      KIND_DRAW: begin
        if (!w.filled) begin
          // outline edges taken literally: zero size still puts down
          // two sides (or two rows), one pixel before the origin
          for (i = xs; i < xs + wd; i++) begin
            plot(i, ys, w.ink);
            plot(i, ys + ht - 1, w.ink);
          end
          for (j = ys; j < ys + ht; j++) begin
            plot(xs, j, w.ink);
            plot(xs + wd - 1, j, w.ink);
          end
        end else begin
          // fill only the on-screen part; same result, fewer iterations
          x_lo = (xs < 0) ? 0 : xs;
          x_hi = (xs + wd - 1 > COLS - 1) ? COLS - 1 : xs + wd - 1;
          y_lo = (ys < 0) ? 0 : ys;
          y_hi = (ys + ht - 1 > ROWS - 1) ? ROWS - 1 : ys + ht - 1;
          for (i = x_lo; i <= x_hi; i++)
            for (j = y_lo; j <= y_hi; j++)
              plot(i, j, w.ink);
        end
      end
      KIND_CLEAR: begin
        foreach (frame_img[k]) frame_img[k] = 8'h00;
      end
      KIND_READ: begin
        answer = frame_img[int'(w.page) * COLS + int'(w.column)];
      end
      default: begin
        // unused kind: no effect, zero answer
      end
    endcase
    return answer;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling schedule: thirds of the run by words taken.
  //   first third  - sender idles 21%, receiver 65%
  //   second third - sender 65%, receiver 21%
  //   last third   - no idling
  // ---------------------------------------------------------------------------
  function automatic int sender_idle_pct();
    if (total_words == 0 || words_taken * 3 < total_words) return 21;
    if (words_taken * 3 < total_words * 2) return 65;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (total_words == 0 || words_taken * 3 < total_words) return 65;
    if (words_taken * 3 < total_words * 2) return 21;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: new word only once the previous one has been taken.
  // Valid is held until the word is accepted; stall is never looked at here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        cur_word = pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, also changed at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every accepted
  // output word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_bytes.push_back(render_word(cur_word));
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual read_byte %02h",
                   $time, read_byte);
          failed = 1'b1;
        end else begin
          if (read_byte !== expected_bytes[0]) begin
            $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                     $time, expected_bytes[0], read_byte);
            failed = 1'b1;
          end
          void'(expected_bytes.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [1:0] k, int xv, int yv, int wv, int hv,
                           bit fl, bit on, int pg, int col);
    word_t w;
    w.kind   = k;
    w.x      = xv[15:0];
    w.y      = yv[15:0];
    w.width  = wv[7:0];
    w.height = hv[7:0];
    w.filled = fl;
    w.ink    = on;
    w.page   = pg[2:0];
    w.column = col[6:0];
    pending_words.push_back(w);
  endtask

  // Mostly near the screen so draws land; now and then any 16-bit value.
  function automatic int rand_coord(int span);
    if ($urandom_range(99) < 8) return int'($signed(16'($urandom())));
    return int'($urandom_range(span + 47)) - 24;
  endfunction

  // Mostly small sizes to keep draws short; a few up to the field maximum.
  function automatic int rand_size();
    if ($urandom_range(99) < 5) return int'($urandom_range(255));
    return int'($urandom_range(24));
  endfunction

  initial begin
    int n, r, last_x, last_y, last_w, last_h, xv, yv;

    // -- directed words --
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 0);             // store starts out clear
    push_word(KIND_DRAW,  0, 0, 255, 255, 1, 1, 0, 0);         // fill beyond whole screen
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 7, 127);
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 0);
    push_word(KIND_DRAW,  -32768, -32768, 255, 255, 0, 0, 0, 0); // far off, nothing drawn
    push_word(KIND_DRAW,  32767, 32767, 255, 255, 1, 0, 0, 0);   // far off, no 16-bit wrap
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 3, 64);
    push_word(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 7, 127);
    push_word(KIND_DRAW,  10, 3, 0, 5, 0, 1, 0, 0);            // zero width: sides at 10 and 9
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 9);
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 10);
    push_word(KIND_DRAW,  20, 9, 4, 0, 0, 1, 0, 0);            // zero height: rows 9 and 8
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 1, 21);
    push_word(KIND_DRAW,  -1, -1, 3, 3, 0, 1, 0, 0);           // outline clipped at corner
    push_word(KIND_DRAW,  126, 62, 5, 5, 1, 1, 0, 0);          // fill clipped at far corner
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 0, 0);
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 7, 127);
    push_word(KIND_DRAW,  30, 30, 0, 0, 1, 1, 0, 0);           // filled, empty
    push_word(KIND_DRAW,  40, 20, 8, 16, 1, 1, 0, 0);
    push_word(KIND_DRAW,  42, 22, 4, 4, 1, 0, 0, 0);           // punch a hole
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 2, 43);
    push_word(KIND_NONE,  -1, -1, 255, 255, 1, 1, 7, 127);     // unused kind
    push_word(KIND_READ,  0, 0, 0, 0, 0, 0, 3, 44);

    // -- random words: a draw followed by reads around it, plus noise --
    last_x = 0; last_y = 0; last_w = 8; last_h = 8;
    for (n = 0; n < 1725; n++) begin
      r = $urandom_range(99);
      if (r < 42) begin
        xv = rand_coord(COLS);
        yv = rand_coord(ROWS);
        last_x = xv; last_y = yv; last_w = rand_size(); last_h = rand_size();
        push_word(KIND_DRAW, xv, yv, last_w, last_h, 1'($urandom_range(1)),
                  ($urandom_range(99) < 65), $urandom_range(7), $urandom_range(127));
      end else if (r < 75) begin
        // aimed at the last rectangle
        push_word(KIND_READ, $urandom(), $urandom(), $urandom_range(255), $urandom_range(255),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  (last_y + int'($urandom_range(last_h + 3)) - 2) >>> 3,
                  last_x + int'($urandom_range(last_w + 3)) - 2);
      end else if (r < 92) begin
        push_word(KIND_READ, $urandom(), $urandom(), $urandom_range(255), $urandom_range(255),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(7), $urandom_range(127));
      end else if (r < 95) begin
        push_word(KIND_CLEAR, $urandom(), $urandom(), $urandom_range(255), $urandom_range(255),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(7), $urandom_range(127));
      end else begin
        push_word(KIND_NONE, $urandom(), $urandom(), $urandom_range(255), $urandom_range(255),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(7), $urandom_range(127));
      end
    end
    total_words = pending_words.size();

    // Synchronous reset; the block then clears its store by itself.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // All words taken, then all results back, then a short quiet spell.
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond every word taking its longest draw plus stalls.
  initial begin
    #120_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
